/* sv/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

  localparam int FFBA_MAX_ENTRIES = 1024;

  localparam logic [2:0] ACT_ALLOC  = 3'd0;
  localparam logic [2:0] ACT_FREE   = 3'd1;
  localparam logic [2:0] ACT_EXTEND = 3'd2;
  localparam logic [2:0] ACT_SHRINK = 3'd3;
  localparam logic [2:0] ACT_ADD    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] address;
    logic [31:0] amount;
  } ffba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_address;
    logic [31:0] free_bytes;
    logic [31:0] used_bytes;
  } ffba_out_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic        used;
  } ffba_entry_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ffba_seq_st_t;

  localparam ffba_entry_t FFBA_SENTINEL = '{base: 32'd0, size: 32'd1, used: 1'b1};

endpackage

/* sv/ffba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ffba_alu.sv */
// Shared 33-bit adder and subtractor used by the arithmetic steps of the sequencer.
module ffba_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [32:0] res
);

  assign res = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});

endmodule

/* sv/ffba_seq.sv */
// Sequencer that walks the block table in RAM through the shared adder.
module ffba_seq
  import ffba_pkg::*;
#(
  parameter int MAX_ENTRIES = FFBA_MAX_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  ffba_in_t     req,
  input  logic         out_free,
  output ffba_seq_st_t st,
  output ffba_out_t    res
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = AW + 1;
  localparam int EW = $bits(ffba_entry_t);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DISP      = 5'd1;
  localparam logic [4:0] S_SCAN_RD   = 5'd2;
  localparam logic [4:0] S_SCAN_CK   = 5'd3;
  localparam logic [4:0] S_INS_RD    = 5'd4;
  localparam logic [4:0] S_INS_WR    = 5'd5;
  localparam logic [4:0] S_INS_W1    = 5'd6;
  localparam logic [4:0] S_ALLOC_FIN = 5'd7;
  localparam logic [4:0] S_FREE_USED = 5'd8;
  localparam logic [4:0] S_NEXT_RD   = 5'd9;
  localparam logic [4:0] S_NEXT_CK   = 5'd10;
  localparam logic [4:0] S_FREE_MN   = 5'd11;
  localparam logic [4:0] S_REM_RD    = 5'd12;
  localparam logic [4:0] S_REM_WR    = 5'd13;
  localparam logic [4:0] S_PREV_RD   = 5'd14;
  localparam logic [4:0] S_PREV_CK   = 5'd15;
  localparam logic [4:0] S_FREE_MP   = 5'd16;
  localparam logic [4:0] S_EXT_CHK   = 5'd17;
  localparam logic [4:0] S_EXT_A     = 5'd18;
  localparam logic [4:0] S_EXT_N     = 5'd19;
  localparam logic [4:0] S_EXT_U     = 5'd20;
  localparam logic [4:0] S_SHR_A     = 5'd21;
  localparam logic [4:0] S_SHR_N     = 5'd22;
  localparam logic [4:0] S_SHR_N2    = 5'd23;
  localparam logic [4:0] S_SHR_U     = 5'd24;
  localparam logic [4:0] S_ADD_RD    = 5'd25;
  localparam logic [4:0] S_ADD_CK    = 5'd26;
  localparam logic [4:0] S_ADD_C2    = 5'd27;
  localparam logic [4:0] S_ADD_C3    = 5'd28;
  localparam logic [4:0] S_DONE      = 5'd29;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);

  logic [4:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]    act_r, act_nxt;
  logic [31:0]   addr_r, addr_nxt, amt_r, amt_nxt, t_r, t_nxt;
  logic [31:0]   managed_r, managed_nxt, used_r, used_nxt, baddr_r, baddr_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [CW-1:0] idx_r, idx_nxt, id_r, id_nxt, k_r, k_nxt, count_r, count_nxt;
  ffba_entry_t   a_r, a_nxt, n_r, n_nxt, ent, wentry;
  logic          rd_zero_r;

  logic [31:0]   alu_a, alu_b;
  logic          alu_sub;
  logic [32:0]   alu_res;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [CW-1:0] id_p1, id_p2, id_m1, k_m1, cnt_m1;

  assign id_p1  = id_r + ONE_CNT;
  assign id_p2  = id_r + CW'(2);
  assign id_m1  = id_r - ONE_CNT;
  assign k_m1   = k_r - ONE_CNT;
  assign cnt_m1 = count_r - ONE_CNT;

  ffba_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  ffba_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The sentinel at index 0 is never written, so it is supplied here.
  assign ent = rd_zero_r ? FFBA_SENTINEL : ffba_entry_t'(ram_rdata);

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    act_nxt     = act_r;
    addr_nxt    = addr_r;
    amt_nxt     = amt_r;
    t_nxt       = t_r;
    managed_nxt = managed_r;
    used_nxt    = used_r;
    baddr_nxt   = baddr_r;
    status_nxt  = status_r;
    idx_nxt     = idx_r;
    id_nxt      = id_r;
    k_nxt       = k_r;
    count_nxt   = count_r;
    a_nxt       = a_r;
    n_nxt       = n_r;
    alu_a       = 32'd0;
    alu_b       = 32'd0;
    alu_sub     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = id_r[AW-1:0];
    ram_raddr   = idx_r[AW-1:0];
    wentry      = a_r;
    st.idle     = 1'b0;
    st.done     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        st.idle = 1'b1;
        if (start) begin
          act_nxt    = req.action;
          addr_nxt   = req.address;
          amt_nxt    = req.amount;
          status_nxt = ST_OK;
          baddr_nxt  = 32'd0;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        idx_nxt = ONE_CNT;
        case (act_r)
          ACT_ALLOC: begin
            alu_a = used_r;
            alu_b = amt_r;
            if (amt_r == 32'd0) begin
              status_nxt = ST_BAD;
              state_nxt  = S_DONE;
            end else if (alu_res > {1'b0, managed_r}) begin
              status_nxt = ST_NOFIT;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          ACT_FREE, ACT_EXTEND, ACT_SHRINK: begin
            if (addr_r == 32'd0) begin
              status_nxt = ST_BAD;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          ACT_ADD: begin
            alu_a   = amt_r;
            alu_b   = 32'd1;
            alu_sub = 1'b1;
            if (amt_r == 32'd0) begin
              status_nxt = ST_BAD;
              state_nxt  = S_DONE;
            end else if (addr_r == 32'd0) begin
              // A region at address zero loses its first byte to the sentinel.
              addr_nxt = 32'd1;
              amt_nxt  = alu_res[31:0];
              if (alu_res[31:0] == 32'd0) begin
                status_nxt = ST_BAD;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_ADD_RD;
              end
            end else begin
              state_nxt = S_ADD_RD;
            end
          end
          default: begin
            status_nxt = ST_BAD;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_SCAN_RD: begin
        if (idx_r >= count_r) begin
          status_nxt = (act_r == ACT_ALLOC) ? ST_NOFIT : ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        alu_a   = ent.size;
        alu_b   = amt_r;
        alu_sub = 1'b1;
        idx_nxt = idx_r + ONE_CNT;
        state_nxt = S_SCAN_RD;
        if (act_r == ACT_ALLOC) begin
          if (!ent.used && !alu_res[32]) begin
            a_nxt  = ent;
            id_nxt = idx_r;
            t_nxt  = alu_res[31:0];
            if (alu_res[31:0] != 32'd0) begin
              if (count_r >= MAX_CNT) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                k_nxt     = count_r;
                state_nxt = S_INS_RD;
              end
            end else begin
              state_nxt = S_ALLOC_FIN;
            end
          end
        end else if (ent.base == addr_r) begin
          a_nxt  = ent;
          id_nxt = idx_r;
          t_nxt  = alu_res[31:0];
          case (act_r)
            ACT_FREE: begin
              if (!ent.used) begin
                status_nxt = ST_BAD;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_FREE_USED;
              end
            end
            ACT_SHRINK: begin
              if (alu_res[32] || alu_res[31:0] == 32'd0) begin
                status_nxt = ST_BAD;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_NEXT_RD;
              end
            end
            default: state_nxt = S_NEXT_RD;
          endcase
        end
      end
      S_INS_RD: begin
        ram_raddr = k_m1[AW-1:0];
        state_nxt = (k_r == id_p1) ? S_INS_W1 : S_INS_WR;
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[AW-1:0];
        wentry    = ent;
        k_nxt     = k_m1;
        state_nxt = S_INS_RD;
      end
      S_INS_W1: begin
        alu_a     = a_r.base;
        alu_b     = amt_r;
        ram_we    = 1'b1;
        ram_waddr = id_p1[AW-1:0];
        wentry    = '{base: alu_res[31:0], size: t_r, used: 1'b0};
        count_nxt = count_r + ONE_CNT;
        state_nxt = S_ALLOC_FIN;
      end
      S_ALLOC_FIN: begin
        alu_a     = used_r;
        alu_b     = amt_r;
        ram_we    = 1'b1;
        wentry    = '{base: a_r.base, size: amt_r, used: 1'b1};
        used_nxt  = alu_res[31:0];
        baddr_nxt = a_r.base;
        state_nxt = S_DONE;
      end
      S_FREE_USED: begin
        alu_a      = used_r;
        alu_b      = a_r.size;
        alu_sub    = 1'b1;
        used_nxt   = alu_res[31:0];
        a_nxt.used = 1'b0;
        state_nxt  = S_NEXT_RD;
      end
      S_NEXT_RD: begin
        ram_raddr = id_p1[AW-1:0];
        if (id_p1 < count_r) begin
          state_nxt = S_NEXT_CK;
        end else if (act_r == ACT_FREE) begin
          state_nxt = S_PREV_RD;
        end else begin
          status_nxt = ST_BAD;
          state_nxt  = S_DONE;
        end
      end
      S_NEXT_CK: begin
        alu_a = a_r.base;
        alu_b = a_r.size;
        n_nxt = ent;
        if (!ent.used && alu_res == {1'b0, ent.base}) begin
          case (act_r)
            ACT_FREE:   state_nxt = S_FREE_MN;
            ACT_EXTEND: state_nxt = S_EXT_CHK;
            default:    state_nxt = S_SHR_A;
          endcase
        end else if (act_r == ACT_FREE) begin
          state_nxt = S_PREV_RD;
        end else begin
          status_nxt = ST_BAD;
          state_nxt  = S_DONE;
        end
      end
      S_FREE_MN: begin
        alu_a      = a_r.size;
        alu_b      = n_r.size;
        a_nxt.size = alu_res[31:0];
        k_nxt      = id_p2;
        ret_nxt    = S_PREV_RD;
        state_nxt  = S_REM_RD;
      end
      S_REM_RD: begin
        ram_raddr = k_r[AW-1:0];
        if (k_r >= count_r) begin
          count_nxt = cnt_m1;
          state_nxt = ret_r;
        end else begin
          state_nxt = S_REM_WR;
        end
      end
      S_REM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_m1[AW-1:0];
        wentry    = ent;
        k_nxt     = k_r + ONE_CNT;
        state_nxt = S_REM_RD;
      end
      S_PREV_RD: begin
        ram_raddr = id_m1[AW-1:0];
        state_nxt = S_PREV_CK;
      end
      S_PREV_CK: begin
        alu_a = ent.base;
        alu_b = ent.size;
        if (!ent.used && alu_res == {1'b0, a_r.base}) begin
          n_nxt     = ent;
          state_nxt = S_FREE_MP;
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FREE_MP: begin
        alu_a     = n_r.size;
        alu_b     = a_r.size;
        ram_we    = 1'b1;
        ram_waddr = id_m1[AW-1:0];
        wentry    = '{base: n_r.base, size: alu_res[31:0], used: 1'b0};
        k_nxt     = id_p1;
        ret_nxt   = S_DONE;
        state_nxt = S_REM_RD;
      end
      S_EXT_CHK: begin
        alu_a   = n_r.size;
        alu_b   = amt_r;
        alu_sub = 1'b1;
        t_nxt   = alu_res[31:0];
        if (alu_res[32]) begin
          status_nxt = ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_EXT_A;
        end
      end
      S_EXT_A: begin
        alu_a     = a_r.size;
        alu_b     = amt_r;
        ram_we    = 1'b1;
        wentry    = '{base: a_r.base, size: alu_res[31:0], used: a_r.used};
        state_nxt = S_EXT_N;
      end
      S_EXT_N: begin
        alu_a = n_r.base;
        alu_b = amt_r;
        if (t_r == 32'd0) begin
          // The next block is used up entirely and leaves the table.
          k_nxt     = id_p2;
          ret_nxt   = S_EXT_U;
          state_nxt = S_REM_RD;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = id_p1[AW-1:0];
          wentry    = '{base: alu_res[31:0], size: t_r, used: 1'b0};
          state_nxt = S_EXT_U;
        end
      end
      S_EXT_U: begin
        alu_a = used_r;
        alu_b = amt_r;
        if (a_r.used) begin
          used_nxt = alu_res[31:0];
        end
        state_nxt = S_DONE;
      end
      S_SHR_A: begin
        ram_we    = 1'b1;
        wentry    = '{base: a_r.base, size: t_r, used: a_r.used};
        state_nxt = S_SHR_N;
      end
      S_SHR_N: begin
        alu_a     = n_r.size;
        alu_b     = amt_r;
        t_nxt     = alu_res[31:0];
        state_nxt = S_SHR_N2;
      end
      S_SHR_N2: begin
        alu_a     = n_r.base;
        alu_b     = amt_r;
        alu_sub   = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = id_p1[AW-1:0];
        wentry    = '{base: alu_res[31:0], size: t_r, used: 1'b0};
        state_nxt = S_SHR_U;
      end
      S_SHR_U: begin
        alu_a   = used_r;
        alu_b   = amt_r;
        alu_sub = 1'b1;
        if (a_r.used) begin
          used_nxt = alu_res[31:0];
        end
        state_nxt = S_DONE;
      end
      S_ADD_RD: begin
        ram_raddr = cnt_m1[AW-1:0];
        state_nxt = S_ADD_CK;
      end
      S_ADD_CK: begin
        alu_a = ent.base;
        alu_b = ent.size;
        if ({1'b0, addr_r} < alu_res) begin
          status_nxt = ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_ADD_C2;
        end
      end
      S_ADD_C2: begin
        alu_a = addr_r;
        alu_b = amt_r;
        if (alu_res[32] && alu_res[31:0] != 32'd0) begin
          status_nxt = ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_ADD_C3;
        end
      end
      S_ADD_C3: begin
        alu_a     = managed_r;
        alu_b     = amt_r;
        state_nxt = S_DONE;
        if (alu_res[32]) begin
          status_nxt = ST_BAD;
        end else if (count_r >= MAX_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = count_r[AW-1:0];
          wentry      = '{base: addr_r, size: amt_r, used: 1'b0};
          managed_nxt = alu_res[31:0];
          count_nxt   = count_r + ONE_CNT;
        end
      end
      S_DONE: begin
        alu_a   = managed_r;
        alu_b   = used_r;
        alu_sub = 1'b1;
        if (out_free) begin
          st.done   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res.status        = status_r;
  assign res.block_address = baddr_r;
  assign res.free_bytes    = alu_res[31:0];
  assign res.used_bytes    = used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= ONE_CNT;
      managed_r <= 32'd0;
      used_r    <= 32'd0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      managed_r <= managed_nxt;
      used_r    <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r     <= ret_nxt;
    act_r     <= act_nxt;
    addr_r    <= addr_nxt;
    amt_r     <= amt_nxt;
    t_r       <= t_nxt;
    baddr_r   <= baddr_nxt;
    status_r  <= status_nxt;
    idx_r     <= idx_nxt;
    id_r      <= id_nxt;
    k_r       <= k_nxt;
    a_r       <= a_nxt;
    n_r       <= n_nxt;
    rd_zero_r <= (ram_raddr == '0);
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= ONE_CNT && count_r <= MAX_CNT)
    else $error("entry count out of range");

  a_no_sentinel_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ram_waddr != '0)
    else $error("write to sentinel entry");

  a_used_le_managed: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= managed_r)
    else $error("used bytes exceed managed bytes");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st.done |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle after a result");

endmodule

/* sv/first_fit_block_allocator_core.sv */
// Top level of the first-fit block allocator: handshakes and result register.
//
//   channel  direction  handshake            payload
//   in_      request    in_valid / in_stall    ffba_in_t  (action, address, amount)
//   out_     result     out_valid / out_stall  ffba_out_t (status, address, totals)
//
// A request that is rejected early finishes soonest; the table scan reads one entry
// at a time through the single RAM read port, and an insert or remove shifts the
// entries one at a time.
// Reset leaves a table holding only the sentinel; no clearing pass is needed.
// in_stall is high while a request is in work; a stalled result holds the
// sequencer in its final step, and no new request is taken until it moves on.
module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int MAX_ENTRIES = FFBA_MAX_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ffba_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ffba_out_t out_data
);

  ffba_seq_st_t seq_st;
  ffba_out_t    seq_res;
  ffba_out_t    out_r;
  logic         out_valid_r;
  logic         out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !seq_st.idle;

  ffba_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && seq_st.idle),
    .req      (in_data),
    .out_free (out_free),
    .st       (seq_st),
    .res      (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_st.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_st.done) begin
      out_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
